FILE: rtl/core/formant_speech_frame_synth_assert.svh
// ---------------------------------------------------------------------------
// Formant speech frame synthesizer assertion macros
// Shared concurrent assertion wrappers; they compile to nothing under SYNTH.
// ---------------------------------------------------------------------------
`ifndef FORMANT_SPEECH_FRAME_SYNTH_ASSERT_SVH
`define FORMANT_SPEECH_FRAME_SYNTH_ASSERT_SVH

`ifndef SYNTH
`define FSS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("formant synth assertion failed");
`define FSS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("formant synth assertion failed");
`else
`define FSS_ASSERT(name, clk, rst_n, prop)
`define FSS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

FILE: rtl/core/fss_pkg.sv
// ---------------------------------------------------------------------------
// Formant speech frame synthesizer package
// Types, constants and small tables shared by the synthesizer modules.
// ---------------------------------------------------------------------------
package fss_pkg;

  typedef enum logic [0:0] {
    CfgNoiseSeed     = 1'b0,
    CfgStepsPerFrame = 1'b1
  } fss_cfg_idx_e;

  typedef struct packed {
    logic         we;
    fss_cfg_idx_e idx;
    logic [15:0]  wdata;
  } fss_cfg_t;

  typedef struct packed {
    logic [7:0]      flags;
    logic [2:0][7:0] freq;
    logic [2:0][7:0] amp;
    logic [7:0]      pitch;
  } fss_item_t;

  typedef struct packed {
    logic        noise_sel;
    logic [13:0] noise_val;
    logic [19:0] tri_sum;
    logic        done;
    logic        skip;
  } fss_mid_t;

  localparam logic [15:0]        LfsrMask      = 16'hB400;
  localparam logic [15:0]        SeedReset     = 16'd44257;
  localparam logic [7:0]         StepsReset    = 8'd140;
  localparam logic [10:0]        PhaseCycle    = 11'd1536;
  localparam logic signed [11:0] PhaseMid      = 12'sd768;
  localparam logic signed [11:0] TriOffset     = 12'sd384;
  localparam logic signed [13:0] NoiseGain     = 14'sd50;
  localparam logic [8:0]         PitchLimit    = 9'd510;
  localparam logic [21:0]        RecipThree    = 22'd2796203;
  localparam int unsigned        RecipShift    = 23;
  localparam logic signed [15:0] SampleMax     = 16'sh7FFF;
  localparam logic signed [15:0] SampleMin     = -16'sh8000;

  // Fraction step per noise sample, indexed by the rate code of the flags.
  function automatic logic [7:0] noise_step(input logic [2:0] rate_code);
    logic [7:0] step;
    unique case (rate_code)
      3'd0, 3'd1: step = 8'd128;
      3'd2:       step = 8'd115;
      3'd3:       step = 8'd51;
      3'd4:       step = 8'd38;
      default:    step = 8'd26;
    endcase
    return step;
  endfunction

endpackage

FILE: rtl/core/fss_core.sv
// ---------------------------------------------------------------------------
// Formant speech frame synthesizer state stage
// Advances the frame, pitch, oscillator and noise state by one sample and
// registers the oscillator sum, the noise value and the noise select with the frame end flags.
// ---------------------------------------------------------------------------
`include "formant_speech_frame_synth_assert.svh"

module fss_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fss_pkg::fss_item_t item_i,
  input  fss_pkg::fss_cfg_t  cfg_i,
  output fss_pkg::fss_mid_t  mid_o
);

  logic [8:0]       pc_q, pc_d;
  logic [2:0][10:0] phase_q, phase_d;
  logic [1:0]       sub_q, sub_d;
  logic [7:0]       step_q, step_d;
  logic [11:0]      uc_q, uc_d;
  logic [7:0]       frac_q, frac_d;
  logic [7:0]       level_q, level_d;
  logic [15:0]      lfsr_q, lfsr_d;
  logic [7:0]       spf_q, spf_d;
  fss_pkg::fss_mid_t mid_q, mid_d;

  logic              unvoiced;
  logic              late;
  logic [8:0]        frac_sum;
  logic [15:0]       lfsr_shift;
  logic [7:0]        level_new;
  logic [11:0]       unv_len;
  logic [11:0]       uc_inc;
  logic [1:0]        sub_inc;
  logic [8:0]        pc_inc;
  logic [7:0]        step_inc;
  logic [10:0]       ph_add;
  logic signed [11:0] dphase;
  logic signed [11:0] dabs;
  logic signed [11:0] tri_s;
  logic signed [19:0] prod [3];
  logic signed [19:0] tri_sum;

  logic              phase_ok;
  logic              done_seen;
  logic              cnt_clear;

  always_comb begin
    unvoiced   = |item_i.flags[7:3];
    late       = ({pc_q, 1'b0} > ({2'b00, item_i.pitch} + {1'b0, item_i.pitch, 1'b0}));
    frac_sum   = {1'b0, frac_q} + {1'b0, fss_pkg::noise_step(item_i.flags[2:0])};
    lfsr_shift = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? fss_pkg::LfsrMask : 16'd0);
    level_new  = frac_sum[8] ? lfsr_shift[7:0] : level_q;
    unv_len    = {item_i.flags[7:3], 7'd0} + 12'd16;
    uc_inc     = uc_q + 12'd1;
    sub_inc    = sub_q + 2'd1;
    pc_inc     = pc_q + 9'd1;
    step_inc   = step_q + 8'd1;
    ph_add     = '0;

    tri_sum = '0;
    for (int i = 0; i < 3; i++) begin
      dphase  = $signed({1'b0, phase_q[i]}) - fss_pkg::PhaseMid;
      dabs    = dphase[11] ? -dphase : dphase;
      tri_s   = dabs - fss_pkg::TriOffset;
      prod[i] = 20'(tri_s) * $signed(20'(item_i.amp[i]));
      tri_sum = tri_sum + prod[i];
    end

    mid_d.noise_sel = unvoiced || ((item_i.flags[2:0] != 3'd0) && late);
    mid_d.noise_val = 14'($signed(level_new)) * fss_pkg::NoiseGain;
    mid_d.tri_sum   = tri_sum;
    mid_d.done      = 1'b0;
    mid_d.skip      = 1'b0;

    pc_d    = pc_q;
    phase_d = phase_q;
    sub_d   = sub_q;
    step_d  = step_q;
    uc_d    = uc_q;
    frac_d  = frac_q;
    level_d = level_q;
    lfsr_d  = lfsr_q;
    spf_d   = spf_q;

    if (en_i) begin
      if (mid_d.noise_sel) begin
        frac_d = frac_sum[7:0];
        if (frac_sum[8]) begin
          lfsr_d  = lfsr_shift;
          level_d = lfsr_shift[7:0];
        end
      end
      if (unvoiced) begin
        uc_d       = uc_inc;
        mid_d.done = (uc_inc >= unv_len) || (uc_inc == 12'd0);
        mid_d.skip = mid_d.done;
      end else begin
        if (!mid_d.noise_sel) begin
          for (int i = 0; i < 3; i++) begin
            ph_add     = phase_q[i] + 11'(item_i.freq[i]);
            phase_d[i] = (ph_add >= fss_pkg::PhaseCycle) ? ph_add - fss_pkg::PhaseCycle
                                                         : ph_add;
          end
        end
        if (sub_inc == 2'd3) begin
          sub_d = 2'd0;
          if (pc_inc >= {item_i.pitch, 1'b0}) begin
            pc_d    = 9'd0;
            phase_d = '0;
          end else begin
            pc_d = pc_inc;
          end
          step_d     = step_inc;
          mid_d.done = (step_inc >= spf_q) || (step_inc == 8'd0);
        end else begin
          sub_d = sub_inc;
        end
      end
      if (mid_d.done) begin
        sub_d  = 2'd0;
        step_d = 8'd0;
        uc_d   = 12'd0;
      end
    end

    if (cfg_i.we) begin
      unique case (cfg_i.idx)
        fss_pkg::CfgNoiseSeed:     lfsr_d = cfg_i.wdata;
        fss_pkg::CfgStepsPerFrame: spf_d  = cfg_i.wdata[7:0];
        default:                   lfsr_d = lfsr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      phase_q <= '0;
      sub_q   <= '0;
      step_q  <= '0;
      uc_q    <= '0;
      frac_q  <= '0;
      level_q <= '0;
      lfsr_q  <= fss_pkg::SeedReset;
      spf_q   <= fss_pkg::StepsReset;
    end else begin
      pc_q    <= pc_d;
      phase_q <= phase_d;
      sub_q   <= sub_d;
      step_q  <= step_d;
      uc_q    <= uc_d;
      frac_q  <= frac_d;
      level_q <= level_d;
      lfsr_q  <= lfsr_d;
      spf_q   <= spf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

  assign phase_ok  = (phase_q[0] < fss_pkg::PhaseCycle) && (phase_q[1] < fss_pkg::PhaseCycle) &&
                     (phase_q[2] < fss_pkg::PhaseCycle);
  assign done_seen = en_i && mid_d.done;
  assign cnt_clear = (sub_q == 2'd0) && (step_q == 8'd0) && (uc_q == 12'd0);

  `FSS_ASSERT(a_pitch_range, clk_i, rst_ni, pc_q < fss_pkg::PitchLimit)
  `FSS_ASSERT(a_phase_range, clk_i, rst_ni, phase_ok)
  `FSS_ASSERT(a_sub_range, clk_i, rst_ni, sub_q != 2'd3)
  `FSS_ASSERT(a_done_clears, clk_i, rst_ni, done_seen |=> cnt_clear)

endmodule

FILE: rtl/core/fss_scale.sv
// ---------------------------------------------------------------------------
// Formant speech frame synthesizer output scaling
// Scales the oscillator sum by 25/12 toward zero, selects noise or voice and
// saturates the result to a 16-bit sample.
// ---------------------------------------------------------------------------
module fss_scale (
  input  fss_pkg::fss_mid_t  mid_i,
  output logic signed [15:0] sample_o
);

  logic               neg;
  logic [18:0]        mag;
  logic [22:0]        mag25;
  logic [20:0]        quarter;
  logic [42:0]        recip_prod;
  logic [19:0]        quot;

  always_comb begin
    neg        = mid_i.tri_sum[19];
    mag        = neg ? 19'(-$signed(mid_i.tri_sum)) : mid_i.tri_sum[18:0];
    mag25      = {mag, 4'd0} + {1'b0, mag, 3'd0} + {4'd0, mag};
    quarter    = mag25[22:2];
    recip_prod = 43'(quarter) * 43'(fss_pkg::RecipThree);
    quot       = recip_prod[fss_pkg::RecipShift +: 20];

    if (mid_i.noise_sel) begin
      sample_o = 16'($signed(mid_i.noise_val));
    end else if (neg) begin
      sample_o = (quot > 20'd32768) ? fss_pkg::SampleMin : 16'(-$signed({1'b0, quot}));
    end else begin
      sample_o = (quot > 20'd32767) ? fss_pkg::SampleMax : $signed(quot[15:0]);
    end
  end

endmodule

FILE: rtl/core/formant_speech_frame_synth.sv
// ---------------------------------------------------------------------------
// Formant speech frame synthesizer
// Throughput: one item per cycle while out_ready_i does not stall the output; an
// item passes the input register, state stage and output register in that order.
// Reset: asynchronous active low; counters, phases and noise state clear, the
// noise shift register loads 44257 and the frame length loads 140 steps.
// ---------------------------------------------------------------------------
module formant_speech_frame_synth (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        frame_flags_i,
  input  logic [7:0]        formant_freq_one_i,
  input  logic [7:0]        formant_freq_two_i,
  input  logic [7:0]        formant_freq_three_i,
  input  logic [7:0]        formant_amp_one_i,
  input  logic [7:0]        formant_amp_two_i,
  input  logic [7:0]        formant_amp_three_i,
  input  logic [7:0]        pitch_period_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [15:0] audio_sample_o,
  output logic              frame_done_o,
  output logic              skip_next_frame_o,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);

  fss_pkg::fss_item_t in_item;
  fss_pkg::fss_item_t s1_item_q;
  fss_pkg::fss_cfg_t  cfg;
  fss_pkg::fss_mid_t  mid;

  logic               s1_valid_q, s1_valid_d;
  logic               s2_valid_q, s2_valid_d;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] sample;
  logic signed [15:0] sample_q;
  logic               done_q;
  logic               skip_q;

  logic in_xfer;
  logic out_adv;
  logic s2_free;
  logic s2_adv;
  logic s1_go;

  always_comb begin
    in_item.flags   = frame_flags_i;
    in_item.freq[0] = formant_freq_one_i;
    in_item.freq[1] = formant_freq_two_i;
    in_item.freq[2] = formant_freq_three_i;
    in_item.amp[0]  = formant_amp_one_i;
    in_item.amp[1]  = formant_amp_two_i;
    in_item.amp[2]  = formant_amp_three_i;
    in_item.pitch   = pitch_period_i;

    cfg.we    = cfg_we_i;
    cfg.idx   = fss_pkg::fss_cfg_idx_e'(cfg_idx_i);
    cfg.wdata = cfg_wdata_i;
  end

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s2_adv     = s2_valid_q && out_adv;
  assign s2_free    = !s2_valid_q || out_adv;
  assign s1_go      = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_xfer ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);
  assign s2_valid_d  = s1_go ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_q);
  assign out_valid_d = s2_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item;
    end
    if (s2_adv) begin
      sample_q <= sample;
      done_q   <= mid.done;
      skip_q   <= mid.skip;
    end
  end

  fss_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_go),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .mid_o  (mid)
  );

  fss_scale u_scale (
    .mid_i    (mid),
    .sample_o (sample)
  );

  assign out_valid_o       = out_valid_q;
  assign audio_sample_o    = sample_q;
  assign frame_done_o      = done_q;
  assign skip_next_frame_o = skip_q;

endmodule
